[rtl/core/twcr_pkg.sv]
package twcr_pkg;

  // Texture and screen geometry
  localparam int TEX_SIZE    = 64;
  localparam int SCREEN_H    = 64;
  localparam int TEX_BITS    = $clog2(TEX_SIZE);
  localparam int FACE_STRIDE = TEX_SIZE * TEX_SIZE;

  // Field widths fixed by the item formats
  localparam int STORE_AW    = 14;
  localparam int STORE_DEPTH = 1 << STORE_AW;
  localparam int COLOR_W     = 32;
  localparam int COL_W       = 10;
  localparam int POS_W       = 18;
  localparam int POS_FRAC    = 8;
  localparam int DIR_W       = 16;
  localparam int DIST_W      = 16;
  localparam int PIX_Y_W     = 6;
  localparam int FRAC_W      = 22;

  // Span arithmetic
  localparam int HALF_H   = SCREEN_H / 2;
  localparam int SPAN_NUM = SCREEN_H * 128;
  localparam int HQ_W     = $clog2(SPAN_NUM + 1);
  localparam int SPAN_W   = $clog2(2 * SPAN_NUM + 2);
  localparam int ROW_W    = HQ_W + 2;
  localparam int Y_W      = $clog2(SCREEN_H + 1);
  localparam int TQ_W     = TEX_BITS + 2;

  // Shared divider
  localparam int DVD_W = $clog2(SPAN_NUM * TEX_SIZE + 1);
  localparam int DVS_W = (DIST_W > SPAN_W) ? DIST_W : SPAN_W;

  // Item queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_DRAW = 1'b1
  } twcr_op_t;

  typedef enum logic [1:0] {
    FACE_EAST  = 2'd0,
    FACE_WEST  = 2'd1,
    FACE_SOUTH = 2'd2,
    FACE_NORTH = 2'd3
  } twcr_face_t;

  typedef struct packed {
    twcr_op_t                op;
    logic [STORE_AW-1:0]     index;
    logic [COLOR_W-1:0]      color;
    logic [COL_W-1:0]        column;
    twcr_face_t              face;
    logic [TEX_BITS-1:0]     tx;
    logic [DIST_W-1:0]       wall_dist;
  } twcr_item_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [QCNT_W-1:0] count;
  } twcr_qstat_t;

endpackage

[rtl/core/twcr_channels.sv]
interface twcr_in_if import twcr_pkg::*;
  ;
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [STORE_AW-1:0]      texel_index;
  logic [COLOR_W-1:0]       texel_color;
  logic [COL_W-1:0]         column;
  logic                     hit_axis;
  logic                     step_x_positive;
  logic                     step_y_positive;
  logic [POS_W-1:0]         viewer_x;
  logic [POS_W-1:0]         viewer_y;
  logic signed [DIR_W-1:0]  ray_dir_x;
  logic signed [DIR_W-1:0]  ray_dir_y;
  logic [DIST_W-1:0]        wall_distance;

  modport source (
    output valid, operation, texel_index, texel_color, column, hit_axis,
           step_x_positive, step_y_positive, viewer_x, viewer_y,
           ray_dir_x, ray_dir_y, wall_distance,
    input  ready
  );

  modport sink (
    input  valid, operation, texel_index, texel_color, column, hit_axis,
           step_x_positive, step_y_positive, viewer_x, viewer_y,
           ray_dir_x, ray_dir_y, wall_distance,
    output ready
  );
endinterface

interface twcr_out_if import twcr_pkg::*;
  ;
  logic                valid;
  logic                ready;
  logic [COL_W-1:0]    pixel_x;
  logic [PIX_Y_W-1:0]  pixel_y;
  logic [COLOR_W-1:0]  pixel_color;
  logic                last;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, last,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, last,
    output ready
  );
endinterface

[rtl/core/twcr_front.sv]
module twcr_front import twcr_pkg::*; (
  twcr_in_if.sink     in_ch,
  input  twcr_qstat_t qstat,
  output logic        push,
  output twcr_item_t  item
);

  logic [DIST_W-1:0]           dist_c;
  logic [POS_FRAC-1:0]         pos_frac;
  logic signed [DIR_W-1:0]     dir_s;
  logic signed [DIR_W+DIST_W:0] prod;
  logic [FRAC_W-1:0]           frac;
  logic [FRAC_W+TEX_BITS:0]    tx_wide;

  always_comb begin
    in_ch.ready = !qstat.full;
    push        = in_ch.valid && !qstat.full;

    // zero distance counts as one LSB
    dist_c = (in_ch.wall_distance == '0) ? DIST_W'(1) : in_ch.wall_distance;

    // coordinate along the wall: y for an x-line hit, x for a y-line hit
    pos_frac = in_ch.hit_axis ? in_ch.viewer_x[POS_FRAC-1:0] : in_ch.viewer_y[POS_FRAC-1:0];
    dir_s    = in_ch.hit_axis ? in_ch.ray_dir_x : in_ch.ray_dir_y;
    prod     = dir_s * $signed({1'b0, dist_c});

    // only the fraction survives, so negative sums wrap
    frac    = {pos_frac, {(FRAC_W-POS_FRAC){1'b0}}} + prod[FRAC_W-1:0];
    tx_wide = {{(TEX_BITS+1){1'b0}}, frac} * (FRAC_W+TEX_BITS+1)'(TEX_SIZE);

    item.op        = twcr_op_t'(in_ch.operation);
    item.index     = in_ch.texel_index;
    item.color     = in_ch.texel_color;
    item.column    = in_ch.column;
    item.tx        = tx_wide[FRAC_W +: TEX_BITS];
    item.wall_dist = dist_c;
    if (!in_ch.hit_axis) begin
      item.face = in_ch.step_x_positive ? FACE_EAST : FACE_WEST;
    end else begin
      item.face = in_ch.step_y_positive ? FACE_SOUTH : FACE_NORTH;
    end
  end

endmodule

[rtl/core/twcr_queue.sv]
module twcr_queue import twcr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  twcr_item_t  item,
  input  logic        pop,
  output twcr_item_t  head,
  output twcr_qstat_t qstat
);

  twcr_item_t        slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  always_comb begin
    head        = slots_r[rd_ptr_r];
    qstat.empty = (count_r == '0);
    qstat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
    qstat.count = count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      priority if (push && !pop) count_r <= count_r + QCNT_W'(1);
      else if (pop && !push)     count_r <= count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= item;
  end

endmodule

[rtl/core/twcr_div.sv]
module twcr_div import twcr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   trial;
  logic             fits;
  logic [DVS_W:0]   diff;

  // one quotient bit a cycle, dividend bits shift out as quotient bits shift in
  always_comb begin
    trial = {rem_r, quo_r[DVD_W-1]};
    fits  = (trial >= {1'b0, dvs_r});
    diff  = trial - {1'b0, dvs_r};
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W - 1);
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        quo_r <= {quo_r[DVD_W-2:0], fits};
        rem_r <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/core/twcr_back.sv]
module twcr_back import twcr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  twcr_item_t  head,
  input  twcr_qstat_t qstat,
  output logic        pop,
  twcr_out_if.source  out_ch
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LAUNCH1,
    ST_WAIT1,
    ST_GEOM,
    ST_LAUNCH2,
    ST_WAIT2,
    ST_LAUNCH3,
    ST_WAIT3,
    ST_ROWS
  } state_t;

  state_t state_r;

  // draw context
  logic [COL_W-1:0]        column_r;
  twcr_face_t              face_r;
  logic [TEX_BITS-1:0]     tx_r;
  logic [DIST_W-1:0]       dist_r;
  logic signed [ROW_W-1:0] top_r;
  logic signed [ROW_W-1:0] bottom_r;
  logic [Y_W-1:0]          ystart_r;
  logic [Y_W-1:0]          yend_r;
  logic [SPAN_W-1:0]       span_r;
  logic [HQ_W-1:0]         s0_r;
  logic [TQ_W-1:0]         step_q_r;
  logic [SPAN_W-1:0]       step_r_r;
  logic [Y_W-1:0]          y_r;
  logic [TQ_W-1:0]         tq_r;
  logic [SPAN_W-1:0]       tr_r;

  // read stage and output register
  logic                    rd_valid_r;
  logic [COL_W-1:0]        rd_x_r;
  logic [PIX_Y_W-1:0]      rd_y_r;
  logic                    rd_last_r;
  logic [COLOR_W-1:0]      rd_data_r;
  logic                    out_valid_r;
  logic [COL_W-1:0]        out_x_r;
  logic [PIX_Y_W-1:0]      out_y_r;
  logic [COLOR_W-1:0]      out_color_r;
  logic                    out_last_r;

  logic [COLOR_W-1:0]      tex_mem [STORE_DEPTH];

  logic                    div_start;
  logic                    div_done;
  logic [DVD_W-1:0]        div_dividend;
  logic [DVS_W-1:0]        div_divisor;
  logic [DVD_W-1:0]        div_quo;
  logic [DVS_W-1:0]        div_rem;

  logic                    mem_we;
  logic [STORE_AW-1:0]     rd_addr;
  logic                    out_load;
  logic                    rd_free;
  logic                    row_issue;
  logic                    row_last;
  logic [HQ_W-1:0]         hq;
  logic [ROW_W-1:0]        hq_ext;
  logic                    top_adj;
  logic signed [ROW_W-1:0] top_nxt;
  logic signed [ROW_W-1:0] bottom_nxt;
  logic [Y_W-1:0]          ystart_nxt;
  logic [Y_W-1:0]          yend_nxt;
  logic [SPAN_W-1:0]       span_nxt;
  logic [HQ_W-1:0]         s0_nxt;
  logic [SPAN_W:0]         r_sum;
  logic                    wrap;
  logic [SPAN_W-1:0]       tr_nxt;
  logic [TQ_W-1:0]         tq_nxt;

  twcr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    pop    = (state_r == ST_IDLE) && !qstat.empty;
    mem_we = pop && (head.op == OP_LOAD);

    div_start = (state_r == ST_LAUNCH1) || (state_r == ST_LAUNCH2) ||
                (state_r == ST_LAUNCH3);
    unique case (state_r)
      ST_LAUNCH2: begin
        div_dividend = DVD_W'(TEX_SIZE);
        div_divisor  = DVS_W'(span_r);
      end
      ST_LAUNCH3: begin
        div_dividend = DVD_W'(s0_r) * DVD_W'(TEX_SIZE);
        div_divisor  = DVS_W'(span_r);
      end
      default: begin
        div_dividend = DVD_W'(SPAN_NUM);
        div_divisor  = DVS_W'(dist_r);
      end
    endcase

    // half span q = hq + rem/dist; top rounds outward only while it stays on screen
    hq         = div_quo[HQ_W-1:0];
    hq_ext     = {{(ROW_W-HQ_W){1'b0}}, hq};
    top_adj    = (div_rem != '0) && (hq < HQ_W'(HALF_H));
    top_nxt    = ROW_W'(HALF_H) - hq_ext - ROW_W'(top_adj);
    bottom_nxt = ROW_W'(HALF_H) + hq_ext;

    ystart_nxt = top_r[ROW_W-1] ? '0 : Y_W'(top_r);
    yend_nxt   = (bottom_r > $signed(ROW_W'(SCREEN_H))) ? Y_W'(SCREEN_H) : Y_W'(bottom_r);
    span_nxt   = SPAN_W'(bottom_r - top_r);
    s0_nxt     = top_r[ROW_W-1] ? HQ_W'(-top_r) : '0;

    // texture row steps by TEX_SIZE/span each row, remainder carried
    r_sum  = {1'b0, tr_r} + {1'b0, step_r_r};
    wrap   = (r_sum >= {1'b0, span_r});
    tr_nxt = wrap ? SPAN_W'(r_sum - {1'b0, span_r}) : SPAN_W'(r_sum);
    tq_nxt = tq_r + step_q_r + TQ_W'(wrap);

    out_load  = rd_valid_r && (!out_valid_r || out_ch.ready);
    rd_free   = !rd_valid_r || out_load;
    row_issue = (state_r == ST_ROWS) && rd_free;
    row_last  = (y_r == yend_r - Y_W'(1));
    rd_addr   = STORE_AW'(face_r) * STORE_AW'(FACE_STRIDE) +
                STORE_AW'(tq_r[TEX_BITS-1:0]) * STORE_AW'(TEX_SIZE) +
                STORE_AW'(tx_r);

    out_ch.valid       = out_valid_r;
    out_ch.pixel_x     = out_x_r;
    out_ch.pixel_y     = out_y_r;
    out_ch.pixel_color = out_color_r;
    out_ch.last        = out_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (pop && (head.op == OP_DRAW)) begin
            column_r <= head.column;
            face_r   <= head.face;
            tx_r     <= head.tx;
            dist_r   <= head.wall_dist;
            state_r  <= ST_LAUNCH1;
          end
        end
        ST_LAUNCH1: state_r <= ST_WAIT1;
        ST_WAIT1: begin
          if (div_done) begin
            top_r    <= top_nxt;
            bottom_r <= bottom_nxt;
            state_r  <= ST_GEOM;
          end
        end
        ST_GEOM: begin
          ystart_r <= ystart_nxt;
          yend_r   <= yend_nxt;
          span_r   <= span_nxt;
          s0_r     <= s0_nxt;
          state_r  <= ST_LAUNCH2;
        end
        ST_LAUNCH2: state_r <= ST_WAIT2;
        ST_WAIT2: begin
          if (div_done) begin
            step_q_r <= div_quo[TQ_W-1:0];
            step_r_r <= div_rem[SPAN_W-1:0];
            state_r  <= ST_LAUNCH3;
          end
        end
        ST_LAUNCH3: state_r <= ST_WAIT3;
        ST_WAIT3: begin
          if (div_done) begin
            tq_r    <= div_quo[TQ_W-1:0];
            tr_r    <= div_rem[SPAN_W-1:0];
            y_r     <= ystart_r;
            state_r <= ST_ROWS;
          end
        end
        ST_ROWS: begin
          if (rd_free) begin
            y_r  <= y_r + Y_W'(1);
            tq_r <= tq_nxt;
            tr_r <= tr_nxt;
            if (row_last) state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      // texel read in flight; hold while the output register is full
      if (row_issue) begin
        rd_valid_r <= 1'b1;
        rd_x_r     <= column_r;
        rd_y_r     <= PIX_Y_W'(y_r);
        rd_last_r  <= row_last;
      end else if (out_load) begin
        rd_valid_r <= 1'b0;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
        out_x_r     <= rd_x_r;
        out_y_r     <= rd_y_r;
        out_color_r <= rd_data_r;
        out_last_r  <= rd_last_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) tex_mem[head.index] <= head.color;
    if (row_issue) rd_data_r <= tex_mem[rd_addr];
  end

endmodule

[rtl/core/textured_wall_column_render_unit.sv]
// Wall column renderer for a grid raycaster. A load beat writes one texel into
// a 16384-word store (four faces of 64x64); texels are undefined until loaded
// and a draw must only touch loaded entries. A draw beat carries the ray hit of
// one screen column and yields one pixel beat per visible row, top to bottom,
// with last set on the final one. Beats enter a four-deep queue, so intake runs
// ahead of the render engine. The engine retires a load as soon as it pops it. A draw
// first runs its setup as three 20-step divisions in turn on
// one shared bit-serial divider, then yields one pixel per cycle (up to 64), limited
// by the single read port of the texture store and by output backpressure.
module textured_wall_column_render_unit import twcr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  twcr_in_if.sink    in_ch,
  twcr_out_if.source out_ch
);

  logic        push;
  logic        pop;
  twcr_item_t  item;
  twcr_item_t  head;
  twcr_qstat_t qstat;

  twcr_front u_front (
    .in_ch (in_ch),
    .qstat (qstat),
    .push  (push),
    .item  (item)
  );

  twcr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .item  (item),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  twcr_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .qstat  (qstat),
    .pop    (pop),
    .out_ch (out_ch)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("render engine popped an empty queue");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qstat.full)
    else $error("front pushed into a full queue");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(push) && !$past(pop) |->
      qstat.count == $past(qstat.count) + QCNT_W'(1))
    else $error("queue fill count lost a beat");

endmodule
